>>> rtl/u8u16_pkg.sv
`default_nettype none
package u8u16_pkg;

   // byte classes and limits
   localparam logic [7:0] ASCII_MAX    = 8'h7F;
   localparam logic [7:0] CONT_MIN     = 8'h80;
   localparam logic [7:0] CONT_MAX     = 8'hBF;
   localparam logic [7:0] LEAD2_MIN    = 8'hC2;
   localparam logic [7:0] LEAD2_MAX    = 8'hDF;
   localparam logic [7:0] LEAD3_MIN    = 8'hE0;
   localparam logic [7:0] LEAD3_MAX    = 8'hEF;
   localparam logic [7:0] LEAD4_MIN    = 8'hF0;
   localparam logic [7:0] LEAD4_MAX    = 8'hF4;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] LEAD_F4      = 8'hF4;
   localparam logic [7:0] CONT_MIN_E0  = 8'hA0;
   localparam logic [7:0] CONT_MAX_ED  = 8'h9F;
   localparam logic [7:0] CONT_MIN_F0  = 8'h90;
   localparam logic [7:0] CONT_MAX_F4  = 8'h8F;

   localparam logic [20:0] SUPP_BASE   = 21'h10000;
   localparam logic [5:0]  HI_SURR_TOP = 6'b110110;   // D800 >> 10
   localparam logic [5:0]  LO_SURR_TOP = 6'b110111;   // DC00 >> 10

   localparam int          QUEUE_DEPTH = 2;
   localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);

   // what closes a job after its invalid results
   typedef enum logic [1:0] {
      TAIL_NONE    = 2'd0,
      TAIL_SINGLE  = 2'd1,
      TAIL_PAIR    = 2'd2,
      TAIL_INVALID = 2'd3
   } tail_type;

   // one decoded byte, as handed from front to back
   typedef struct packed {
      logic [1:0]  inv_count;
      tail_type    tail;
      logic [20:0] scalar;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

>>> rtl/u8u16_front.sv
`default_nettype none
module u8u16_front
   import u8u16_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] byte_in,
   output      logic       push,
   output      job_type    job
);

   logic [20:0] partial_ff, partial_in;
   logic [1:0]  expected_ff, expected_in;
   logic [1:0]  held_ff, held_in;
   logic [7:0]  lead_ff, lead_in;

   always_comb begin
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic        cont_ok;
      logic [20:0] shifted;

      lo = CONT_MIN;
      hi = CONT_MAX;
      if (held_ff == 2'd1) begin
         unique case (lead_ff)
            LEAD_E0: lo = CONT_MIN_E0;
            LEAD_ED: hi = CONT_MAX_ED;
            LEAD_F0: lo = CONT_MIN_F0;
            LEAD_F4: hi = CONT_MAX_F4;
            default: ;
         endcase
      end
      cont_ok = (byte_in >= lo) && (byte_in <= hi);
      shifted = {partial_ff[14:0], byte_in[5:0]};

      partial_in     = partial_ff;
      expected_in    = expected_ff;
      held_in        = held_ff;
      lead_in        = lead_ff;
      job.inv_count  = 2'd0;
      job.tail       = TAIL_NONE;
      job.scalar     = '0;

      if (expected_ff != 2'd0 && cont_ok) begin
         if (expected_ff == 2'd1) begin
            job.scalar     = shifted;
            job.tail       = (shifted < SUPP_BASE) ? TAIL_SINGLE : TAIL_PAIR;
            partial_in     = '0;
            expected_in    = 2'd0;
            held_in        = 2'd0;
            lead_in        = '0;
         end else begin
            partial_in  = shifted;
            expected_in = expected_ff - 2'd1;
            held_in     = held_ff + 2'd1;
         end
      end else begin
         // no open sequence, or a broken one: flush what is held, then decode byte afresh
         if (expected_ff != 2'd0) job.inv_count = held_ff;
         partial_in  = '0;
         expected_in = 2'd0;
         held_in     = 2'd0;
         lead_in     = '0;
         priority if (byte_in <= ASCII_MAX) begin
            job.tail       = TAIL_SINGLE;
            job.scalar     = {13'd0, byte_in};
         end else if (byte_in >= LEAD2_MIN && byte_in <= LEAD2_MAX) begin
            partial_in  = {16'd0, byte_in[4:0]};
            expected_in = 2'd1;
            held_in     = 2'd1;
            lead_in     = byte_in;
         end else if (byte_in >= LEAD3_MIN && byte_in <= LEAD3_MAX) begin
            partial_in  = {17'd0, byte_in[3:0]};
            expected_in = 2'd2;
            held_in     = 2'd1;
            lead_in     = byte_in;
         end else if (byte_in >= LEAD4_MIN && byte_in <= LEAD4_MAX) begin
            partial_in  = {18'd0, byte_in[2:0]};
            expected_in = 2'd3;
            held_in     = 2'd1;
            lead_in     = byte_in;
         end else begin
            job.tail = TAIL_INVALID;
         end
      end
   end

   assign push = accept && ((job.inv_count != 2'd0) || (job.tail != TAIL_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         expected_ff <= 2'd0;
         held_ff     <= 2'd0;
         lead_ff     <= '0;
      end else if (accept) begin
         partial_ff  <= partial_in;
         expected_ff <= expected_in;
         held_ff     <= held_in;
         lead_ff     <= lead_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/u8u16_queue.sv
`default_nettype none
module u8u16_queue
   import u8u16_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output      job_type head,
   output q_status_type status
);

   localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W+1)'(QUEUE_DEPTH);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == DEPTH_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QPTR_W+1)'(1);
      if (do_pop && !do_push) count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/u8u16_back.sv
`default_nettype none
module u8u16_back
   import u8u16_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire job_type      head,
   input  wire q_status_type q_status,
   output      logic         pop,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      logic [15:0]  rsp_unit_out,
   output      logic [20:0]  rsp_code_point_out,
   output      logic         rsp_status,
   output      logic         rsp_last_unit
);

   logic        cur_valid_ff, cur_valid_in;
   job_type     cur_ff;
   logic [1:0]  inv_left_ff, inv_left_in;
   logic        low_half_ff, low_half_in;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_unit_ff, out_unit_in;
   logic [20:0] out_cp_ff, out_cp_in;
   logic        out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;

   logic        advance, emit, last;
   logic [19:0] supp_off;

   assign advance  = !out_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && advance;
   assign supp_off = 20'(cur_ff.scalar - SUPP_BASE);

   always_comb begin
      out_unit_in   = '0;
      out_cp_in     = '0;
      out_status_in = 1'b1;
      last          = 1'b0;
      if (inv_left_ff != 2'd0) begin
         last = (inv_left_ff == 2'd1) && (cur_ff.tail == TAIL_NONE);
      end else begin
         unique case (cur_ff.tail)
            TAIL_SINGLE: begin
               out_unit_in   = cur_ff.scalar[15:0];
               out_cp_in     = cur_ff.scalar;
               out_status_in = 1'b0;
               last          = 1'b1;
            end
            TAIL_PAIR: begin
               out_unit_in   = low_half_ff ? {LO_SURR_TOP, supp_off[9:0]}
                                           : {HI_SURR_TOP, supp_off[19:10]};
               out_cp_in     = cur_ff.scalar;
               out_status_in = 1'b0;
               last          = low_half_ff;
            end
            TAIL_INVALID: last = 1'b1;
            default:      last = 1'b1;
         endcase
      end
      out_last_in = last;
   end

   assign pop = !q_status.empty && (!cur_valid_ff || (emit && last));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      inv_left_in  = inv_left_ff;
      low_half_in  = low_half_ff;
      if (emit) begin
         if (inv_left_ff != 2'd0) inv_left_in = inv_left_ff - 2'd1;
         else if (cur_ff.tail == TAIL_PAIR) low_half_in = 1'b1;
         if (last) cur_valid_in = 1'b0;
      end
      if (pop) begin
         cur_valid_in = 1'b1;
         inv_left_in  = head.inv_count;
         low_half_in  = 1'b0;
      end
      out_valid_in = advance ? cur_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
      if (emit) begin
         out_unit_ff   <= out_unit_in;
         out_cp_ff     <= out_cp_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         inv_left_ff  <= 2'd0;
         low_half_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         inv_left_ff  <= inv_left_in;
         low_half_ff  <= low_half_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_unit_out       = out_unit_ff;
   assign rsp_code_point_out = out_cp_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_last_unit      = out_last_ff;

endmodule
`default_nettype wire

>>> rtl/utf8_to_utf16_transcoder.sv
// Path: request -> job queue -> current job -> output register -> rsp.
// Throughput: a request per cycle unless req_stall, a result per cycle unless
//   rsp_stall; a request with n results (up to four) holds the result unit till
//   all are out; the two-entry job queue absorbs this before req_stall rises.
// Reset: synchronous, active high; decoder goes idle, queue and output empty.
`default_nettype none
module utf8_to_utf16_transcoder
   import u8u16_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_byte_in,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [15:0] rsp_unit_out,
   output      logic [20:0] rsp_code_point_out,
   output      logic        rsp_status,
   output      logic        rsp_last_unit
);

   // Front: per-byte UTF-8 decode and validation. Each accepted request is
   // reduced to a job: how many held bytes are flushed as invalid, plus what
   // the byte itself closes with (a BMP unit, a surrogate pair, an invalid
   // result, or nothing when it opens or extends a sequence).
   logic         accept;
   logic         push;
   job_type      job;

   // Queue between the two halves; only full blocks the request side.
   job_type      head;
   q_status_type q_status;
   logic         pop;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   u8u16_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .byte_in (req_byte_in),
      .push    (push),
      .job     (job)
   );

   u8u16_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // Back: expands one job into its results, one per cycle unless rsp_stall,
   // into the output register. last_unit marks the final result of each request.
   u8u16_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_unit_out       (rsp_unit_out),
      .rsp_code_point_out (rsp_code_point_out),
      .rsp_status         (rsp_status),
      .rsp_last_unit      (rsp_last_unit)
   );

endmodule
`default_nettype wire
